>>> hw/rtl/lbp_pkg.sv
package lbp_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_FIELD_BITS = 32;
    localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
    localparam int MAX_CMD_BYTES  = 5;
    localparam int CMD_BITS       = 8 * MAX_CMD_BYTES;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_BYTES  = 2'd1,
        OP_ALIGN  = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    // One classified item: the bytes it completes, then optionally a marker
    // result (flush marker or error report).
    typedef struct packed {
        logic [CMD_BITS-1:0] bytes;
        logic [2:0]          nbytes;
        logic                tail;
        logic                tail_last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       error;
    } t_result;

endpackage

>>> hw/rtl/lsb_first_bit_packer.sv
// LSB-first bit packer. Items are accepted one per clock while full is low;
// the front end merges each field with the fewer than eight pending bits at
// acceptance time and queues the completed bytes (plus a flush marker or an
// error report) for the back end. The back end delivers one transaction per
// clock while results are taken, through a single output register; an item
// holds the result side until its 0 to 5 results (4 for a full 32-bit field)
// are out. The sustained rate is therefore set by that output register, and
// the command queue (QUEUE_DEPTH entries) absorbs bursts on the input side.
module lsb_first_bit_packer
    import lbp_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_bit_count,
    input  logic [2:0]  i_byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic        o_error
);

    logic    w_accept;
    logic    w_enq;
    t_cmd    w_front_cmd;
    t_cmd    w_q_cmd;
    logic    w_q_empty;
    logic    w_q_pop;
    t_result w_result;

    assign w_accept = push && !full;

    lbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_bit_count  (i_bit_count),
        .i_byte_count (i_byte_count),
        .o_enq        (w_enq),
        .o_cmd        (w_front_cmd)
    );

    lbp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_enq),
        .i_data  (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    lbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_cmd_empty (w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_data_byte  = w_result.data_byte;
    assign o_byte_valid = w_result.byte_valid;
    assign o_last       = w_result.last;
    assign o_error      = w_result.error;

endmodule

>>> hw/rtl/lbp_front.sv
module lbp_front
    import lbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_value,
    input  logic [5:0]  i_bit_count,
    input  logic [2:0]  i_byte_count,
    output logic        o_enq,
    output t_cmd        o_cmd
);

    logic [6:0]  r_pend_bits;
    logic [2:0]  r_pend_count;
    logic [6:0]  n_pend_bits;
    logic [2:0]  n_pend_count;

    logic        w_bad;
    logic [32:0] w_mask;
    logic [31:0] w_field;
    logic [38:0] w_acc;
    logic [38:0] w_rest;
    logic [5:0]  w_total;
    logic [2:0]  w_app_bytes;
    logic [2:0]  w_nb;
    logic        w_has_pad;
    t_cmd        w_cmd;

    assign w_bad   = (i_bit_count == 6'd0) || (i_bit_count > 6'(FIELD_LIMIT));
    assign w_mask  = ~({33{1'b1}} << i_bit_count);
    assign w_field = i_value & w_mask[31:0];
    assign w_acc   = {32'd0, r_pend_bits} | ({7'd0, w_field} << r_pend_count);
    assign w_total = {3'd0, r_pend_count} + i_bit_count;
    assign w_app_bytes = w_total[5:3];
    assign w_rest  = w_acc >> {w_app_bytes, 3'b000};
    assign w_nb    = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign w_has_pad = (r_pend_count != 3'd0);

    always_comb begin
        w_cmd        = '0;
        n_pend_bits  = r_pend_bits;
        n_pend_count = r_pend_count;
        unique case (t_op'(i_op))
            OP_APPEND: begin
                if (w_bad) begin
                    w_cmd.tail = 1'b1;
                end else begin
                    w_cmd.bytes  = {1'b0, w_acc};
                    w_cmd.nbytes = w_app_bytes;
                    n_pend_bits  = w_rest[6:0];
                    n_pend_count = w_total[2:0];
                end
            end
            OP_BYTES: begin
                // A partial byte goes out zero padded ahead of the value bytes.
                w_cmd.bytes  = w_has_pad ? {i_value, 1'b0, r_pend_bits} : {8'd0, i_value};
                w_cmd.nbytes = w_nb + {2'd0, w_has_pad};
                n_pend_bits  = '0;
                n_pend_count = '0;
            end
            OP_ALIGN: begin
                w_cmd.bytes  = {33'd0, r_pend_bits};
                w_cmd.nbytes = {2'd0, w_has_pad};
                n_pend_bits  = '0;
                n_pend_count = '0;
            end
            OP_FLUSH: begin
                w_cmd.bytes     = {33'd0, r_pend_bits};
                w_cmd.nbytes    = {2'd0, w_has_pad};
                w_cmd.tail      = 1'b1;
                w_cmd.tail_last = 1'b1;
                n_pend_bits     = '0;
                n_pend_count    = '0;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_count <= '0;
        end else if (i_accept) begin
            r_pend_bits  <= n_pend_bits;
            r_pend_count <= n_pend_count;
        end
    end

    // Items that complete no byte and carry no marker never reach the back end.
    assign o_enq = i_accept && ((w_cmd.nbytes != 3'd0) || w_cmd.tail);
    assign o_cmd = w_cmd;

endmodule

>>> hw/rtl/lbp_queue.sv
module lbp_queue
    import lbp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/lbp_back.sv
module lbp_back
    import lbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_cmd    r_cmd;
    logic    r_busy;
    logic [2:0] r_idx;
    t_result r_out;
    logic    r_out_valid;

    logic    w_out_free;
    logic    w_emit;
    logic    w_at_tail;
    logic    w_last_of_cmd;
    logic    w_finish;
    t_result w_res;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_emit     = r_busy && w_out_free;
    assign w_at_tail  = (r_idx == r_cmd.nbytes);
    assign w_last_of_cmd = w_at_tail || ((r_idx + 3'd1 == r_cmd.nbytes) && !r_cmd.tail);
    assign w_finish   = w_emit && w_last_of_cmd;
    assign o_cmd_pop  = (!r_busy || w_finish) && !i_cmd_empty;

    always_comb begin
        if (w_at_tail) begin
            w_res.data_byte  = 8'd0;
            w_res.byte_valid = 1'b0;
            w_res.last       = r_cmd.tail_last;
            w_res.error      = !r_cmd.tail_last;
        end else begin
            w_res.data_byte  = r_cmd.bytes[{r_idx, 3'b000} +: 8];
            w_res.byte_valid = 1'b1;
            w_res.last       = 1'b0;
            w_res.error      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (w_emit) begin
                r_idx <= r_idx + 3'd1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

>>> hw/rtl/lbp_checker.sv
module lbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_data_byte,
    input logic       o_byte_valid,
    input logic       o_last,
    input logic       o_error
);

    // Reset leaves nothing to deliver.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    // An error report carries no byte and no flush mark.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (!o_byte_valid && !o_last && o_data_byte == 8'd0))
        else $error("malformed error result");

    // A result without a byte is either the flush marker or an error, never both.
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> ((o_last != o_error) && o_data_byte == 8'd0))
        else $error("malformed marker result");

    // A waiting result is held until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_byte) && $stable(o_byte_valid)
                              && $stable(o_last) && $stable(o_error)))
        else $error("result changed while stalled");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_data_byte  (o_data_byte),
    .o_byte_valid (o_byte_valid),
    .o_last       (o_last),
    .o_error      (o_error)
);
